FILE: hw/rtl/pfd_pkg.sv
// Shared types, constants and helper functions of the filtered-derivative PID core.
// Used by pfd_serial_unit and pid_filtered_derivative_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned GAIN_W    = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned RES_W     = 66;
    localparam int unsigned OPA_W     = 64;
    localparam int unsigned OPB_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_TAU = 3'd4;

    localparam logic [OPB_W-1:0] FC_Q     = 32'd52152;
    localparam logic [29:0]      BETA_MAX = 30'h2000_0000;

    localparam logic signed [RES_W-1:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [RES_W-1:0] S32_MIN = -66'sd2147483648;

    typedef struct packed {
        logic start;
        logic is_div;
        logic negate;
    } pfd_req_t;

    function automatic logic signed [RES_W-1:0] sx66(input logic [DATA_W-1:0] v);
        sx66 = signed'({{(RES_W-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [RES_W-1:0] v);
        if (v > S32_MAX)
        begin
            sat32 = 32'h7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            sat32 = 32'h8000_0000;
        end
        else
        begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    function automatic logic [DATA_W:0] mag33(input logic signed [DATA_W:0] v);
        if (v[DATA_W])
        begin
            mag33 = 33'(-v);
        end
        else
        begin
            mag33 = 33'(v);
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pfd_serial_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiplier and restoring divider.
// Depends on pfd_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module pfd_serial_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pfd_pkg::pfd_req_t                  req,
    input  wire logic [pfd_pkg::OPA_W-1:0]          opa,
    input  wire logic [pfd_pkg::OPB_W-1:0]          opb,
    output logic                                    done,
    output logic signed [pfd_pkg::RES_W-1:0]        result
);

    logic                            busy_reg;
    logic                            fin_reg;
    logic                            done_reg;
    logic                            is_div_reg;
    logic                            neg_reg;
    logic [5:0]                      cnt_reg;
    logic [pfd_pkg::RES_W-1:0]       acc_reg;
    logic [pfd_pkg::RES_W-1:0]       mcand_reg;
    logic [pfd_pkg::OPB_W-1:0]       opb_reg;
    logic [pfd_pkg::OPA_W-1:0]       dvd_reg;
    logic [pfd_pkg::OPB_W-1:0]       rem_reg;
    logic signed [pfd_pkg::RES_W-1:0] res_reg;

    logic [pfd_pkg::OPB_W:0]         trial;
    logic [pfd_pkg::OPB_W:0]         trial_sub;
    logic                            fits;
    logic [pfd_pkg::RES_W-1:0]       mag;

    assign trial     = {rem_reg, dvd_reg[pfd_pkg::OPA_W-1]};
    assign trial_sub = trial - {1'b0, opb_reg};
    assign fits      = (trial >= {1'b0, opb_reg});
    assign mag       = is_div_reg ? {2'b00, dvd_reg} : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            is_div_reg <= 1'b0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg   <= 1'b1;
                fin_reg    <= 1'b0;
                done_reg   <= 1'b0;
                is_div_reg <= req.is_div;
                neg_reg    <= req.negate;
                cnt_reg    <= req.is_div ? 6'd63 : 6'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 6'd1;
                busy_reg <= (cnt_reg != 6'd0);
                fin_reg  <= (cnt_reg == 6'd0);
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= fin_reg;
                fin_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg   <= '0;
            mcand_reg <= {2'b00, opa};
            opb_reg   <= opb;
            dvd_reg   <= opa;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                rem_reg <= fits ? trial_sub[pfd_pkg::OPB_W-1:0] : trial[pfd_pkg::OPB_W-1:0];
                dvd_reg <= {dvd_reg[pfd_pkg::OPA_W-2:0], fits};
            end
            else
            begin
                if (opb_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg <= {mcand_reg[pfd_pkg::RES_W-2:0], 1'b0};
                opb_reg   <= {1'b0, opb_reg[pfd_pkg::OPB_W-1:1]};
            end
        end
        else if (fin_reg)
        begin
            res_reg <= neg_reg ? -signed'(mag) : signed'(mag);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pid_filtered_derivative_core.sv
// Filtered-derivative PID controller core with Q16.16 arithmetic and an output filter.
// One transaction is accepted at a time; up to nine serial operations run on pfd_serial_unit.
// Each transaction runs six multiplies and three divides in sequence before the drive is
// registered, or five multiplies and two divides when out_tau is zero; a new transaction is
// taken only once the previous result has been registered, later while a result is held by a stall.
// Asynchronous active-low reset clears the control, integral, filter and history state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_filtered_derivative_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pfd_pkg::GAIN_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [pfd_pkg::DATA_W-1:0]         target,
    input  wire logic [pfd_pkg::DATA_W-1:0]         measured,
    input  wire logic [pfd_pkg::GAIN_W-1:0]         step_time,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [pfd_pkg::DATA_W-1:0]              drive
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;
    typedef enum logic [3:0] {
        PH_KI, PH_KD, PH_DDIV, PH_ADIV, PH_AMUL, PH_KP, PH_IMUL, PH_BDIV, PH_BMUL
    } phase_t;

    state_t                          state_reg;
    phase_t                          phase_reg;
    logic [pfd_pkg::GAIN_W-1:0]      kp_reg, ki_reg, kd_reg, windup_reg, out_tau_reg;
    logic [pfd_pkg::DATA_W-1:0]      integral_reg, last_meas_reg, df_reg, last_drive_reg;
    logic [pfd_pkg::DATA_W-1:0]      err_reg, chg_reg, deriv_reg, raw_reg, drive_reg;
    logic [pfd_pkg::GAIN_W-1:0]      st_reg;
    logic [15:0]                     a_reg;
    logic [29:0]                     b_reg;
    logic signed [pfd_pkg::RES_W-1:0] tmp_reg;
    logic                            out_valid_reg;

    pfd_pkg::pfd_req_t               req;
    logic [pfd_pkg::OPA_W-1:0]       opa;
    logic [pfd_pkg::OPB_W-1:0]       opb;
    logic                            u_done;
    logic signed [pfd_pkg::RES_W-1:0] u_result;

    logic [pfd_pkg::DATA_W:0]        err_mag, chg_mag, diff_d_mag, diff_o_mag;
    logic signed [pfd_pkg::DATA_W:0] diff_d, diff_o;
    logic signed [pfd_pkg::RES_W-1:0] res_sh, int_sum, windup_ext, df_sum, raw_sum, drv_sum;
    logic [pfd_pkg::DATA_W-1:0]      int_clamp, raw_val;
    logic                            in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    assign err_mag    = pfd_pkg::mag33(signed'({err_reg[31], err_reg}));
    assign chg_mag    = pfd_pkg::mag33(signed'({chg_reg[31], chg_reg}));
    assign diff_d     = signed'({deriv_reg[31], deriv_reg}) - signed'({df_reg[31], df_reg});
    assign diff_o     = signed'({raw_reg[31], raw_reg})
                        - signed'({last_drive_reg[31], last_drive_reg});
    assign diff_d_mag = pfd_pkg::mag33(diff_d);
    assign diff_o_mag = pfd_pkg::mag33(diff_o);

    assign res_sh     = u_result >>> 16;
    assign int_sum    = pfd_pkg::sx66(integral_reg) + res_sh;
    assign windup_ext = signed'({35'd0, windup_reg});
    assign df_sum     = pfd_pkg::sx66(df_reg) + res_sh;
    assign raw_sum    = tmp_reg + res_sh - pfd_pkg::sx66(df_reg);
    assign drv_sum    = pfd_pkg::sx66(last_drive_reg) + res_sh;
    assign raw_val    = pfd_pkg::sat32(raw_sum);

    always_comb
    begin
        if (int_sum < 66'sd0)
        begin
            int_clamp = '0;
        end
        else if (int_sum > windup_ext)
        begin
            int_clamp = {1'b0, windup_reg};
        end
        else
        begin
            int_clamp = int_sum[pfd_pkg::DATA_W-1:0];
        end
    end

    always_comb
    begin
        req.start  = (state_reg == ST_ISSUE);
        req.is_div = 1'b0;
        req.negate = 1'b0;
        opa        = '0;
        opb        = '0;
        unique case (phase_reg)
            PH_KI:
            begin
                opa        = 64'(err_mag);
                opb        = {1'b0, ki_reg};
                req.negate = err_reg[31];
            end
            PH_KD:
            begin
                opa = 64'(chg_mag);
                opb = {1'b0, kd_reg};
            end
            PH_DDIV:
            begin
                opa        = tmp_reg[pfd_pkg::OPA_W-1:0];
                opb        = {1'b0, st_reg};
                req.is_div = 1'b1;
                req.negate = chg_reg[31];
            end
            PH_ADIV:
            begin
                opa        = {17'd0, st_reg, 16'd0};
                opb        = pfd_pkg::FC_Q + {1'b0, st_reg};
                req.is_div = 1'b1;
            end
            PH_AMUL:
            begin
                opa        = 64'(diff_d_mag);
                opb        = {16'd0, a_reg};
                req.negate = diff_d[32];
            end
            PH_KP:
            begin
                opa        = 64'(err_mag);
                opb        = {1'b0, kp_reg};
                req.negate = err_reg[31];
            end
            PH_IMUL:
            begin
                opa = {33'd0, integral_reg[30:0]};
                opb = {1'b0, st_reg};
            end
            PH_BDIV:
            begin
                opa        = {17'd0, st_reg, 16'd0};
                opb        = {1'b0, out_tau_reg};
                req.is_div = 1'b1;
            end
            PH_BMUL:
            begin
                opa        = 64'(diff_o_mag);
                opb        = {2'd0, b_reg};
                req.negate = diff_o[32];
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    pfd_serial_unit u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .done   (u_done),
        .result (u_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_KI;
            kp_reg         <= 31'd65536;
            ki_reg         <= '0;
            kd_reg         <= '0;
            windup_reg     <= '0;
            out_tau_reg    <= '0;
            integral_reg   <= '0;
            last_meas_reg  <= '0;
            df_reg         <= '0;
            last_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pfd_pkg::CFG_KP:      kp_reg      <= cfg_data;
                    pfd_pkg::CFG_KI:      ki_reg      <= cfg_data;
                    pfd_pkg::CFG_KD:      kd_reg      <= cfg_data;
                    pfd_pkg::CFG_WINDUP:  windup_reg  <= cfg_data;
                    pfd_pkg::CFG_OUT_TAU: out_tau_reg <= cfg_data;
                    default:              kp_reg      <= kp_reg;
                endcase
            end

            if (out_acc && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        err_reg       <= pfd_pkg::sat32(pfd_pkg::sx66(target)
                                                        - pfd_pkg::sx66(measured));
                        chg_reg       <= pfd_pkg::sat32(pfd_pkg::sx66(measured)
                                                        - pfd_pkg::sx66(last_meas_reg));
                        last_meas_reg <= measured;
                        st_reg        <= (step_time == '0) ? 31'd1 : step_time;
                        phase_reg     <= PH_KI;
                        state_reg     <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (u_done)
                    begin
                        state_reg <= ST_ISSUE;
                        unique case (phase_reg)
                            PH_KI:
                            begin
                                integral_reg <= int_clamp;
                                phase_reg    <= PH_KD;
                            end
                            PH_KD:
                            begin
                                tmp_reg   <= u_result;
                                phase_reg <= PH_DDIV;
                            end
                            PH_DDIV:
                            begin
                                deriv_reg <= pfd_pkg::sat32(u_result);
                                phase_reg <= PH_ADIV;
                            end
                            PH_ADIV:
                            begin
                                a_reg     <= u_result[15:0];
                                phase_reg <= PH_AMUL;
                            end
                            PH_AMUL:
                            begin
                                df_reg    <= pfd_pkg::sat32(df_sum);
                                phase_reg <= PH_KP;
                            end
                            PH_KP:
                            begin
                                tmp_reg   <= res_sh;
                                phase_reg <= PH_IMUL;
                            end
                            PH_IMUL:
                            begin
                                raw_reg <= raw_val;
                                if (out_tau_reg == '0)
                                begin
                                    last_drive_reg <= raw_val;
                                    state_reg      <= ST_OUT;
                                end
                                else
                                begin
                                    phase_reg <= PH_BDIV;
                                end
                            end
                            PH_BDIV:
                            begin
                                if (u_result > signed'({36'd0, pfd_pkg::BETA_MAX}))
                                begin
                                    b_reg <= pfd_pkg::BETA_MAX;
                                end
                                else
                                begin
                                    b_reg <= u_result[29:0];
                                end
                                phase_reg <= PH_BMUL;
                            end
                            PH_BMUL:
                            begin
                                last_drive_reg <= pfd_pkg::sat32(drv_sum);
                                state_reg      <= ST_OUT;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= last_drive_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Core did not leave idle after accepting a transaction.");

    a_integral_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !integral_reg[31])
        else $error("Integral went negative.");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> state_reg == ST_WAIT)
        else $error("Arithmetic unit finished outside a wait state.");
`endif

endmodule

`default_nettype wire
